@@ design/disk_request_scheduler_assert.svh @@
// assertion macros for the disk request scheduler
`ifndef DISK_REQUEST_SCHEDULER_ASSERT_SVH
`define DISK_REQUEST_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define DRS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DRS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/drs_pkg.sv @@
package drs_pkg;

	localparam int MAX_REQUESTS = 64;
	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [7:0] RESET_START_TRACK = 8'd100;
	localparam logic [2:0] RESET_START_SECTOR = 3'd0;

	localparam logic [8:0] COST_BASE = 9'd110;
	localparam logic [8:0] LATENCY_OFFSET = 9'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POLICY       = 2'd0,
		CFG_START_TRACK  = 2'd1,
		CFG_START_SECTOR = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		POLICY_FCFS = 1'b0,
		POLICY_SSTF = 1'b1
	} policy_t;

	typedef struct packed {
		logic [15:0] arrival_time;
		logic [7:0]  track;
		logic [2:0]  sector;
		logic        last_request;
	} req_t;

	typedef struct packed {
		logic [6:0]  request_number;
		logic [8:0]  latency_tenths;
		logic [19:0] finish_time_tenths;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [15:0] arrival;
		logic [7:0]  track;
		logic [2:0]  sector;
	} entry_t;

	typedef struct packed {
		logic load;
		logic init;
		logic scan_clear;
		logic scan_issue;
		logic fetch;
		logic latch_pick;
		logic jump;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic policy_sstf;
		logic scan_last;
		logic best_found;
		logic out_free;
		logic last_pick;
	} dp_status_t;

	function automatic logic [19:0] times_ten(input logic [15:0] a);
		return 20'({a, 3'b000}) + 20'({a, 1'b0});
	endfunction

	function automatic logic [8:0] cost_of(input logic [7:0] t, input logic [2:0] s,
		input logic [7:0] ht, input logic [2:0] hs);
		logic [7:0] track_gap;
		logic [2:0] rot;
		logic [6:0] rot10;
		track_gap = (t > ht) ? (t - ht) : (ht - t);
		rot = s - hs;
		rot10 = 7'({rot, 3'b000}) + 7'({rot, 1'b0});
		return COST_BASE + 9'(track_gap) + 9'(rot10);
	endfunction

endpackage

@@ design/drs_ctrl.sv @@
module drs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_accept,
	input  logic                 req_last,
	input  drs_pkg::dp_status_t  status,
	output drs_pkg::dp_cmd_t     cmd,
	output logic                 req_stall
);

	typedef enum logic [7:0] {
		S_LOAD     = 8'b0000_0001,
		S_INIT     = 8'b0000_0010,
		S_SCAN     = 8'b0000_0100,
		S_SCAN_END = 8'b0000_1000,
		S_DECIDE   = 8'b0001_0000,
		S_FETCH    = 8'b0010_0000,
		S_LATCH    = 8'b0100_0000,
		S_COMMIT   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_LOAD: begin
				cmd.load = req_accept;
				if (req_accept && req_last) begin
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				cmd.init = 1'b1;
				cmd.scan_clear = 1'b1;
				state_d = status.policy_sstf ? S_SCAN : S_FETCH;
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (status.scan_last) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (status.best_found) begin
					state_d = S_COMMIT;
				end else begin
					// nothing has arrived yet: idle until the earliest arrival
					cmd.jump = 1'b1;
					cmd.scan_clear = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d = S_LATCH;
			end
			S_LATCH: begin
				cmd.latch_pick = 1'b1;
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					if (status.last_pick) begin
						state_d = S_LOAD;
					end else begin
						cmd.scan_clear = 1'b1;
						state_d = status.policy_sstf ? S_SCAN : S_FETCH;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = !(state_q == S_LOAD);

endmodule

@@ design/drs_datapath.sv @@
module drs_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [drs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [drs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  drs_pkg::req_t                   req,
	input  drs_pkg::dp_cmd_t                cmd,
	output drs_pkg::dp_status_t             status,
	input  logic                            rsp_stall,
	output logic                            rsp_valid,
	output drs_pkg::rsp_t                   rsp
);

	localparam int IW = drs_pkg::IDX_W;
	localparam int CW = drs_pkg::CNT_W;

	logic        policy_q;
	logic [7:0]  start_track_q;
	logic [2:0]  start_sector_q;

	drs_pkg::entry_t mem [drs_pkg::MAX_REQUESTS];
	drs_pkg::entry_t rd_data_s1;
	logic [IW-1:0]   rd_addr;
	logic            mem_we;

	logic [CW-1:0]                    count_q;
	logic [CW-1:0]                    done_q;
	logic [drs_pkg::MAX_REQUESTS-1:0] served_q;
	logic [7:0]                       head_track_q;
	logic [2:0]                       head_sector_q;
	logic [19:0]                      clock_q;

	logic [CW-1:0] scan_addr_q;
	logic          scan_valid_s1;
	logic [IW-1:0] scan_idx_s1;

	logic          best_found_q;
	logic [IW-1:0] best_idx_q;
	logic [8:0]    best_cost_q;
	logic [7:0]    best_track_q;
	logic [2:0]    best_sector_q;
	logic [19:0]   best_arr10_q;
	logic          min_found_q;
	logic [19:0]   min_arr_q;

	logic [19:0] arr10_s1;
	logic [8:0]  cost_s1;
	logic        open_s1;
	logic        take_best;
	logic        take_min;
	logic [19:0] base_time;
	logic [19:0] finish_time;
	logic        last_pick;

	logic          rsp_valid_q;
	drs_pkg::rsp_t rsp_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= drs_pkg::POLICY_SSTF;
			start_track_q <= drs_pkg::RESET_START_TRACK;
			start_sector_q <= drs_pkg::RESET_START_SECTOR;
		end else if (cfg_write) begin
			case (cfg_index)
				drs_pkg::CFG_POLICY:       policy_q <= cfg_data[0];
				drs_pkg::CFG_START_TRACK:  start_track_q <= cfg_data;
				drs_pkg::CFG_START_SECTOR: start_sector_q <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	// request store
	assign mem_we = cmd.load && (count_q < CW'(drs_pkg::MAX_REQUESTS));
	assign rd_addr = cmd.fetch ? done_q[IW-1:0] : scan_addr_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[IW-1:0]] <= '{arrival: req.arrival_time, track: req.track,
				sector: req.sector};
		end
		rd_data_s1 <= mem[rd_addr];
	end

	// candidate evaluation
	assign arr10_s1 = drs_pkg::times_ten(rd_data_s1.arrival);
	assign cost_s1 = drs_pkg::cost_of(rd_data_s1.track, rd_data_s1.sector,
		head_track_q, head_sector_q);
	assign open_s1 = scan_valid_s1 && !served_q[scan_idx_s1];
	assign take_best = open_s1 && (arr10_s1 <= clock_q) &&
		(!best_found_q || (cost_s1 < best_cost_q));
	assign take_min = open_s1 && (!min_found_q || (arr10_s1 < min_arr_q));

	assign base_time = (clock_q >= best_arr10_q) ? clock_q : best_arr10_q;
	assign finish_time = base_time + 20'(best_cost_q);
	assign last_pick = (done_q + CW'(1)) == count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			scan_valid_s1 <= 1'b0;
			best_found_q <= 1'b0;
			min_found_q <= 1'b0;
		end else begin
			scan_valid_s1 <= cmd.scan_issue;
			if (cmd.scan_clear) begin
				scan_addr_q <= '0;
				best_found_q <= 1'b0;
				min_found_q <= 1'b0;
			end else begin
				if (cmd.scan_issue) begin
					scan_addr_q <= scan_addr_q + CW'(1);
				end
				if (cmd.latch_pick || take_best) begin
					best_found_q <= 1'b1;
				end
				if (take_min) begin
					min_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_addr_q[IW-1:0];
		if (cmd.latch_pick || take_best) begin
			best_idx_q <= cmd.latch_pick ? done_q[IW-1:0] : scan_idx_s1;
			best_cost_q <= cost_s1;
			best_track_q <= rd_data_s1.track;
			best_sector_q <= rd_data_s1.sector;
			best_arr10_q <= arr10_s1;
		end
		if (take_min) begin
			min_arr_q <= arr10_s1;
		end
	end

	// batch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q <= '0;
			served_q <= '0;
			head_track_q <= drs_pkg::RESET_START_TRACK;
			head_sector_q <= drs_pkg::RESET_START_SECTOR;
			clock_q <= '0;
		end else begin
			if (mem_we) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.init) begin
				done_q <= '0;
				served_q <= '0;
				head_track_q <= start_track_q;
				head_sector_q <= start_sector_q;
				clock_q <= '0;
			end
			if (cmd.jump) begin
				clock_q <= min_arr_q;
			end
			if (cmd.commit) begin
				served_q[best_idx_q] <= 1'b1;
				head_track_q <= best_track_q;
				head_sector_q <= best_sector_q;
				clock_q <= finish_time;
				done_q <= done_q + CW'(1);
				if (last_pick) begin
					count_q <= '0;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.request_number <= 7'(best_idx_q) + 7'd1;
			rsp_q.latency_tenths <= best_cost_q - drs_pkg::LATENCY_OFFSET;
			rsp_q.finish_time_tenths <= finish_time;
			rsp_q.last <= last_pick;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign status.policy_sstf = policy_q == drs_pkg::POLICY_SSTF;
	assign status.scan_last = scan_addr_q == (count_q - CW'(1));
	assign status.best_found = best_found_q;
	assign status.out_free = !rsp_valid_q || !rsp_stall;
	assign status.last_pick = last_pick;

endmodule

@@ design/disk_request_scheduler.sv @@
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  drs_pkg::req_t
// rsp       out        rsp_valid/rsp_stall  drs_pkg::rsp_t
// cfg       in         cfg_write            cfg_index, cfg_data
//
// requests load one per cycle between batches; init follows the last one
// fcfs: fetch, latch, commit per result; sstf: scan, scan end, decide, commit per
// result, and again scan, scan end, decide while idling to the earliest arrival
// the store has a single read port and sstf walks it one entry per cycle
// no clearing pass after reset; req is stalled while a batch is being serviced
// a stalled result holds the last scheduling step, never the loading of requests
`include "disk_request_scheduler_assert.svh"

module disk_request_scheduler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  drs_pkg::req_t                   req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output drs_pkg::rsp_t                   rsp,
	input  logic                            cfg_write,
	input  logic [drs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [drs_pkg::CFG_DATA_W-1:0]  cfg_data
);

	drs_pkg::dp_cmd_t    cmd;
	drs_pkg::dp_status_t status;
	logic                req_accept;

	assign req_accept = req_valid && !req_stall;

	drs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_accept (req_accept),
		.req_last   (req.last_request),
		.status     (status),
		.cmd        (cmd),
		.req_stall  (req_stall)
	);

	drs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	`DRS_ASSERT_IMP(a_commit_slot_free, cmd.commit, !rsp_valid || !rsp_stall, "result overwritten")
	`DRS_ASSERT_IMP(a_commit_has_pick, cmd.commit, status.best_found, "commit without a pick")
	`DRS_ASSERT_NXT(a_last_stalls, req_accept && req.last_request, req_stall, "batch not started")

endmodule
